@@ src/averaged_level_hysteresis_detector_defines.svh @@
// Assertion macros for the detector RTL.
`ifndef AVERAGED_LEVEL_HYSTERESIS_DETECTOR_DEFINES_SVH
`define AVERAGED_LEVEL_HYSTERESIS_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

`define ALHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ALHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ALHD_ASSERT(lbl, clk, rst_n, prop, msg)

`define ALHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/alhd_pkg.sv @@
package alhd_pkg;

    localparam int NUM_SAMPLES_DEF = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int LIMIT_W     = 12;
    localparam int AVG_OUT_W   = 12;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 12'd1000;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 12'd2000;

    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_LOW_LIMIT  = 1'b0;
    localparam t_cfg_idx REG_HIGH_LIMIT = 1'b1;

    typedef struct packed {
        logic [LIMIT_W-1:0] low;
        logic [LIMIT_W-1:0] high;
    } t_limits;

endpackage

@@ src/alhd_front.sv @@
module alhd_front #(
    parameter int NUM_SAMPLES = alhd_pkg::NUM_SAMPLES_DEF,
    parameter int SAMPLE_BITS = alhd_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_W      = SAMPLE_BITS + $clog2(NUM_SAMPLES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_push,
    output logic [SUM_W:0]         o_push_data,
    input  logic                   i_full
);

    localparam int IDX_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SAMPLES - 1);

    logic [SAMPLE_BITS-1:0] mem [NUM_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_old;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;
    logic                   r_warm;
    logic [SAMPLE_BITS-1:0] w_old;
    logic                   w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    // entries not yet written since reset count as zero
    assign w_old = r_warm ? r_old : '0;
    assign n_sum = r_sum - SUM_W'(w_old) + SUM_W'(i_sample);
    assign n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    assign o_push      = w_accept;
    assign o_push_data = {r_warm, n_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_sum  <= '0;
            r_warm <= 1'b0;
        end else if (w_accept) begin
            r_idx <= n_idx;
            r_sum <= n_sum;
            if (r_idx == LAST_IDX) begin
                r_warm <= 1'b1;
            end
        end
    end

    // ring memory; read data prefetches the oldest entry for the next item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem[r_idx] <= i_sample;
            r_old      <= (n_idx == r_idx) ? i_sample : mem[n_idx];
        end else begin
            r_old <= mem[r_idx];
        end
    end

endmodule

@@ src/alhd_queue.sv @@
module alhd_queue #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = alhd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

@@ src/alhd_back.sv @@
`include "averaged_level_hysteresis_detector_defines.svh"

module alhd_back #(
    parameter int NUM_SAMPLES = alhd_pkg::NUM_SAMPLES_DEF,
    parameter int SAMPLE_BITS = alhd_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_W      = SAMPLE_BITS + $clog2(NUM_SAMPLES)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [SUM_W-1:0]                 i_sum,
    input  logic                             i_warm,
    input  alhd_pkg::t_limits                i_limits,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_dark_state,
    output logic [alhd_pkg::AVG_OUT_W-1:0]   o_average
);

    // divide by NUM_SAMPLES: exact multiply by rounded-up reciprocal
    localparam int L_BITS = $clog2(NUM_SAMPLES);
    localparam int SH     = SUM_W + L_BITS;
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam logic [63:0] MUL_FULL =
        ((64'd1 << SH) + 64'(NUM_SAMPLES) - 64'd1) / 64'(NUM_SAMPLES);
    localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL_FULL);
    localparam int CMP_W = (SAMPLE_BITS > alhd_pkg::LIMIT_W) ? SAMPLE_BITS
                                                             : alhd_pkg::LIMIT_W;

    logic                          r_s1_valid;
    logic                          r_s1_warm;
    logic [PROD_W-1:0]             r_s1_prod;
    logic                          r_out_valid;
    logic                          r_level;
    logic                          n_level;
    logic [alhd_pkg::AVG_OUT_W-1:0] r_avg;
    logic                          s1_adv;
    logic                          s1_load;
    logic [CMP_W-1:0]              w_avg;
    logic [CMP_W-1:0]              w_low;
    logic [CMP_W-1:0]              w_high;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign s1_load = i_valid && o_ready;

    assign w_avg  = CMP_W'(r_s1_prod[SH +: SAMPLE_BITS]);
    assign w_low  = CMP_W'(i_limits.low);
    assign w_high = CMP_W'(i_limits.high);

    always_comb begin
        n_level = r_level;
        if (r_s1_warm && (w_avg <= w_low)) begin
            n_level = 1'b1;
        end else if (w_avg >= w_high) begin
            n_level = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_level     <= n_level;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_prod <= PROD_W'(i_sum) * PROD_W'(MUL_C);
            r_s1_warm <= i_warm;
        end
        if (s1_adv) begin
            r_avg <= w_avg[alhd_pkg::AVG_OUT_W-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_dark_state = r_level;
    assign o_average    = r_avg;

    `ALHD_ASSERT_NEXT(a_cold_item_no_dark, i_clk, i_rst_n, s1_adv && !r_s1_warm && !r_level, !r_level, "item before warm-up set dark state")
    `ALHD_ASSERT(a_level_moves_on_load, i_clk, i_rst_n, !$past(s1_adv) |-> $stable(r_level), "level changed without a result load")
    `ALHD_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_prod), "stalled product stage lost its item")

endmodule

@@ src/averaged_level_hysteresis_detector.sv @@
// Averaged level detector with hysteresis.
// Input channel: i_valid / o_ready with i_sample, one converter reading per item.
// Output channel: o_valid / i_ready with o_dark_state and o_average, one result
// per item, in order. o_average is the truncated mean of the last NUM_SAMPLES
// samples; o_dark_state goes to 1 when the mean is at or below the low limit
// (only once the ring has been filled) and to 0 at or above the high limit.
// Limits are written on i_cfg_we with i_cfg_idx (0 low, 1 high); the user must
// write them only while idle, which the block itself does not enforce.
// Throughput: one item per cycle unless stalled, set by the running-sum update
// in the front stage and the one-multiply reciprocal divide in the back.
// Reset (synchronous, active low): ring reads as zero, sum and state clear,
// limits return to 1000 and 2000.
// When the receiver stalls, the output register, the product stage and a
// two-entry queue fill in turn, then o_ready drops; no item is lost.
module averaged_level_hysteresis_detector #(
    parameter int NUM_SAMPLES = alhd_pkg::NUM_SAMPLES_DEF,
    parameter int SAMPLE_BITS = alhd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_dark_state,
    output logic [alhd_pkg::AVG_OUT_W-1:0] o_average,
    input  logic                           i_cfg_we,
    input  alhd_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [alhd_pkg::LIMIT_W-1:0]   i_cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(NUM_SAMPLES);

    alhd_pkg::t_limits r_limits;

    logic             w_push;
    logic [SUM_W:0]   w_push_data;
    logic             w_full;
    logic             w_q_valid;
    logic             w_q_ready;
    logic [SUM_W:0]   w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.low  <= alhd_pkg::LOW_LIMIT_RST;
            r_limits.high <= alhd_pkg::HIGH_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                alhd_pkg::REG_LOW_LIMIT:  r_limits.low  <= i_cfg_data;
                alhd_pkg::REG_HIGH_LIMIT: r_limits.high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    alhd_front #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    alhd_queue #(
        .WIDTH (SUM_W + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    alhd_back #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .o_ready      (w_q_ready),
        .i_sum        (w_q_data[SUM_W-1:0]),
        .i_warm       (w_q_data[SUM_W]),
        .i_limits     (r_limits),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_dark_state (o_dark_state),
        .o_average    (o_average)
    );

endmodule

@@ tb/tb_averaged_level_hysteresis_detector.sv @@
`timescale 1ns / 1ps

module tb_averaged_level_hysteresis_detector;

    localparam int RING_LEN     = alhd_pkg::NUM_SAMPLES_DEF;
    localparam int SAMPLE_MAX   = (1 << alhd_pkg::SAMPLE_BITS_DEF) - 1;
    localparam int PHASE_ITEMS  = 214;
    localparam int NUM_PHASES   = 8;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 300000;

    typedef logic [alhd_pkg::SAMPLE_BITS_DEF-1:0] t_sample;

    typedef struct packed {
        logic                           dark;
        logic [alhd_pkg::AVG_OUT_W-1:0] avg;
    } t_level_reading;

    typedef struct packed {
        t_sample                        sample;
        logic                           typed;
        logic                           dark;
        logic [alhd_pkg::AVG_OUT_W-1:0] avg;
    } t_directed_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    t_sample                        i_sample;
    logic                           o_valid;
    logic                           i_ready;
    logic                           o_dark_state;
    logic [alhd_pkg::AVG_OUT_W-1:0] o_average;
    logic                           i_cfg_we;
    alhd_pkg::t_cfg_idx             i_cfg_idx;
    logic [alhd_pkg::LIMIT_W-1:0]   i_cfg_data;

    averaged_level_hysteresis_detector DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_dark_state (o_dark_state),
        .o_average    (o_average),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // predictor state
    t_sample                      mirror_ring [RING_LEN];
    int                           mirror_idx  = 0;
    int                           mirror_sum  = 0;
    logic                         mirror_warm = 1'b0;
    logic                         mirror_dark = 1'b0;
    logic [alhd_pkg::LIMIT_W-1:0] mirror_low  = alhd_pkg::LOW_LIMIT_RST;
    logic [alhd_pkg::LIMIT_W-1:0] mirror_high = alhd_pkg::HIGH_LIMIT_RST;

    t_level_reading expected_readings [$];
    int             error_count  = 0;
    int             results_seen = 0;
    int             cycle_count  = 0;
    bit             gapless      = 1'b0;

    // warm-up on the zero ring, then a climb to the high limit
    t_directed_row directed_rows [25] = '{
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0},
        '{12'd0,    1'b1, 1'b1, 12'd0},
        '{12'hFFF,  1'b1, 1'b1, 12'd255},
        '{12'hFFF,  1'b0, 1'b0, 12'd0},
        '{12'hFFF,  1'b0, 1'b0, 12'd0},
        '{12'hFFF,  1'b0, 1'b0, 12'd0},
        '{12'hFFF,  1'b0, 1'b0, 12'd0},
        '{12'hFFF,  1'b0, 1'b0, 12'd0},
        '{12'hFFF,  1'b0, 1'b0, 12'd0},
        '{12'hFFF,  1'b1, 1'b0, 12'd2047}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_level_reading next_level_reading(input t_sample s);
        t_level_reading r;
        int             mean;
        mirror_sum = mirror_sum - int'(mirror_ring[mirror_idx]) + int'(s);
        mirror_ring[mirror_idx] = s;
        mean = mirror_sum / RING_LEN;
        if (mirror_warm && mean <= int'(mirror_low)) begin
            mirror_dark = 1'b1;
        end else if (mean >= int'(mirror_high)) begin
            mirror_dark = 1'b0;
        end
        if (mirror_idx == RING_LEN - 1) begin
            mirror_idx  = 0;
            mirror_warm = 1'b1;
        end else begin
            mirror_idx = mirror_idx + 1;
        end
        r.dark = mirror_dark;
        r.avg  = mean[alhd_pkg::AVG_OUT_W-1:0];
        return r;
    endfunction

    task automatic offer_sample(input t_sample s, input logic typed, input t_level_reading want);
        int             gap;
        t_level_reading r;
        gap = gapless ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        r = next_level_reading(s);
        expected_readings.push_back(typed ? want : r);
    endtask

    task automatic write_limit(input alhd_pkg::t_cfg_idx idx,
                               input logic [alhd_pkg::LIMIT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == alhd_pkg::REG_LOW_LIMIT) begin
            mirror_low = value;
        end else begin
            mirror_high = value;
        end
    endtask

    task automatic wait_drained();
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    // mostly steady levels with jitter, some noise bursts
    task automatic send_random_levels(input int count);
        int sent;
        int run;
        int level;
        int jitter;
        int v;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                run = $urandom_range(1, 8);
                for (int k = 0; k < run && sent < count; k++) begin
                    offer_sample(t_sample'($urandom_range(0, SAMPLE_MAX)), 1'b0, '0);
                    sent++;
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: level = 0;
                    1: level = SAMPLE_MAX;
                    2: level = int'(mirror_low);
                    3: level = int'(mirror_high);
                    default: level = $urandom_range(0, SAMPLE_MAX);
                endcase
                jitter = $urandom_range(0, 1) ? 0 : $urandom_range(1, 64);
                run = $urandom_range(1, 40);
                for (int k = 0; k < run && sent < count; k++) begin
                    v = level + int'($urandom_range(0, 2 * jitter)) - jitter;
                    if (v < 0) v = 0;
                    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                    offer_sample(t_sample'(v), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [alhd_pkg::LIMIT_W-1:0] lo;
        logic [alhd_pkg::LIMIT_W-1:0] hi;
        foreach (mirror_ring[k]) mirror_ring[k] = '0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_sample   = '0;
        i_ready    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = alhd_pkg::REG_LOW_LIMIT;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            offer_sample(directed_rows[k].sample, directed_rows[k].typed,
                         '{directed_rows[k].dark, directed_rows[k].avg});
        end
        send_random_levels(PHASE_ITEMS);

        for (int p = 0; p < NUM_PHASES; p++) begin
            i_valid <= 1'b0;
            wait_drained();
            case (p)
                0: begin lo = 12'd0;    hi = 12'd4095; end
                1: begin lo = 12'd4095; hi = 12'd0;    end
                2: begin lo = 12'd4095; hi = 12'd4095; end
                3: begin lo = 12'd0;    hi = 12'd0;    end
                4: begin lo = 12'd1500; hi = 12'd1600; end
                7: begin lo = alhd_pkg::LOW_LIMIT_RST; hi = alhd_pkg::HIGH_LIMIT_RST; end
                default: begin
                    lo = alhd_pkg::LIMIT_W'($urandom_range(0, 4095));
                    hi = alhd_pkg::LIMIT_W'($urandom_range(0, 4095));
                end
            endcase
            write_limit(alhd_pkg::REG_LOW_LIMIT, lo);
            write_limit(alhd_pkg::REG_HIGH_LIMIT, hi);
            gapless = (p == 4);
            send_random_levels(PHASE_ITEMS);
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // result side: random stalls plus one long hold-off to back up the pipe
    initial begin
        int             stall;
        bit             held;
        t_level_reading want;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = gapless ? 0 : $urandom_range(0, 4);
            if (!held && results_seen >= HOLD_AT) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results_seen++;
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected item dark=%0b avg=%0d",
                         $time, o_dark_state, o_average);
                error_count++;
            end else begin
                want = expected_readings.pop_front();
                if (o_dark_state !== want.dark) begin
                    $display("%0t: dark_state expected %0b actual %0b",
                             $time, want.dark, o_dark_state);
                    error_count++;
                end
                if (o_average !== want.avg) begin
                    $display("%0t: average expected %0d actual %0d",
                             $time, want.avg, o_average);
                    error_count++;
                end
            end
        end
    end

endmodule

@@ filelist.f @@
+incdir+src
src/alhd_pkg.sv
src/alhd_front.sv
src/alhd_queue.sv
src/alhd_back.sv
src/averaged_level_hysteresis_detector.sv
tb/tb_averaged_level_hysteresis_detector.sv
